// ----- design/atlfp_pkg.sv -----
// Shared constants for the tag/length field parser.
// No dependencies; used by the parser top level.
package atlfp_pkg;

  localparam int NAME_MAX       = 32;
  localparam int VALUE_LEN_BITS = 20;

  localparam int NAME_IDX_W = $clog2(NAME_MAX);
  localparam int NAME_CNT_W = $clog2(NAME_MAX + 2);

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_EOR   = 2'd2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [7:0] EOH_TEXT [5] = '{8'h3C, 8'h65, 8'h6F, 8'h68, 8'h3E};
  localparam logic [7:0] EOR_TEXT [3] = '{8'h65, 8'h6F, 8'h72};

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

// ----- design/atlfp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module atlfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/adif_tag_length_field_parser.sv -----
// Top level of the tag/length field parser.
// Depends on atlfp_pkg and the name buffer RAM atlfp_ram.
//
// Takes one text byte per cycle and emits name characters, value bytes and
// end-of-record items through a one-entry output register. A byte is taken
// whenever the output register is free or being drained and no name is being
// emitted, so plain text and value bytes run at one byte per cycle. At the '>'
// that closes a field with a valid length, the k buffered name characters are
// read back from the name RAM one per cycle whenever the output register has
// room (the next address is prefetched, hiding the registered read), k at most
// NAME_MAX. A configuration write restarts parsing; no clearing pass is needed.
module adif_tag_length_field_parser
  import atlfp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      skip_header,
  input  logic                      text_valid,
  output logic                      text_ready,
  input  logic [7:0]                text_byte,
  output logic                      item_valid,
  input  logic                      item_ready,
  output logic [1:0]                item_kind,
  output logic [7:0]                data_byte,
  output logic [VALUE_LEN_BITS-1:0] value_length,
  output logic                      field_end,
  output logic                      run_last
);

  typedef enum logic [1:0] {M_HEADER, M_SEEK, M_TAG, M_VALUE} mode_t;
  typedef enum logic {S_RUN, S_EMIT} state_t;
  typedef enum logic [1:0] {L_EMPTY, L_DIGITS, L_BAD, L_CLOSED} len_stat_t;

  localparam int LW = VALUE_LEN_BITS;

  state_t                 state;
  mode_t                  mode;
  len_stat_t              len_stat;
  logic [2:0]             hdr_cnt;
  logic [NAME_CNT_W-1:0]  name_cnt;
  logic [NAME_CNT_W-1:0]  name_keep;
  logic [1:0]             part;
  logic [LW-1:0]          len_acc;
  logic [LW-1:0]          remain;
  logic [NAME_IDX_W-1:0]  emit_idx;
  logic [NAME_IDX_W-1:0]  emit_last;
  logic [7:0]             eor_buf [3];

  logic                   accept;
  logic                   slot_free;
  logic [7:0]             lc;
  logic                   ws;
  logic                   digit;
  logic [LW+3:0]          len_prod;
  logic [NAME_CNT_W-1:0]  emit_cnt;
  logic                   is_eor;
  logic                   len_ok;
  logic                   name_wr;
  logic                   emit_load;
  logic [NAME_IDX_W-1:0]  rd_addr;
  logic [7:0]             rd_data;

  assign cfg_ready  = 1'b1;
  assign slot_free  = !item_valid || item_ready;
  assign text_ready = (state == S_RUN) && slot_free;
  assign accept     = text_valid && text_ready;
  assign emit_load  = (state == S_EMIT) && slot_free;

  assign lc       = to_lower(text_byte);
  assign ws       = is_space(text_byte);
  assign digit    = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign len_prod = {1'b0, len_acc, 3'b000} + {3'b000, len_acc, 1'b0}
                  + {(LW + 4 - 4)'(0), text_byte[3:0]};

  assign emit_cnt = (name_keep > NAME_CNT_W'(NAME_MAX)) ? NAME_CNT_W'(NAME_MAX) : name_keep;
  assign is_eor   = (name_keep == NAME_CNT_W'(3)) && (eor_buf[0] == EOR_TEXT[0])
                 && (eor_buf[1] == EOR_TEXT[1]) && (eor_buf[2] == EOR_TEXT[2]);
  assign len_ok   = (len_stat == L_DIGITS) || (len_stat == L_CLOSED);

  // name characters after leading whitespace go to the buffer while room remains
  assign name_wr = accept && (mode == M_TAG) && (text_byte != CH_GT)
                && (text_byte != CH_COLON) && (part == 2'd0)
                && !(name_cnt == '0 && ws) && (name_cnt < NAME_CNT_W'(NAME_MAX));

  // prefetch: address the entry that the output register will take next
  always_comb begin
    rd_addr = '0;
    if (state == S_EMIT) begin
      rd_addr = emit_load ? emit_idx + 1'b1 : emit_idx;
    end
  end

  atlfp_ram #(
    .WIDTH(8),
    .DEPTH(NAME_MAX)
  ) u_name_ram (
    .clk    (clk),
    .wr_en  (name_wr),
    .wr_addr(name_cnt[NAME_IDX_W-1:0]),
    .wr_data(lc),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_valid <= 1'b0;
    end
    if (rst || cfg_valid) begin
      mode       <= (rst || skip_header) ? M_HEADER : M_SEEK;
      state      <= S_RUN;
      item_valid <= 1'b0;
      hdr_cnt    <= '0;
      name_cnt   <= '0;
      name_keep  <= '0;
      part       <= '0;
      len_acc    <= '0;
      len_stat   <= L_EMPTY;
      remain     <= '0;
      emit_idx   <= '0;
    end else if (state == S_EMIT) begin
      if (emit_load) begin
        item_valid   <= 1'b1;
        item_kind    <= KIND_NAME;
        data_byte    <= rd_data;
        value_length <= remain;
        run_last     <= (emit_idx == emit_last);
        field_end    <= (emit_idx == emit_last) && (remain == '0);
        emit_idx     <= emit_idx + 1'b1;
        if (emit_idx == emit_last) begin
          state <= S_RUN;
        end
      end
    end else if (accept) begin
      case (mode)
        M_HEADER: begin
          if (lc == EOH_TEXT[hdr_cnt]) begin
            if (hdr_cnt == 3'd4) begin
              hdr_cnt <= '0;
              mode    <= M_SEEK;
            end else begin
              hdr_cnt <= hdr_cnt + 3'd1;
            end
          end else begin
            hdr_cnt <= (text_byte == CH_LT) ? 3'd1 : 3'd0;
          end
        end
        M_SEEK: begin
          if (text_byte == CH_LT) begin
            mode <= M_TAG;
          end
        end
        M_TAG: begin
          if (text_byte == CH_GT) begin
            mode <= M_SEEK;
            if (is_eor) begin
              item_valid   <= 1'b1;
              item_kind    <= KIND_EOR;
              data_byte    <= '0;
              value_length <= '0;
              field_end    <= 1'b0;
              run_last     <= 1'b1;
            end else if (len_ok) begin
              remain    <= len_acc;
              emit_idx  <= '0;
              emit_last <= NAME_IDX_W'(emit_cnt - 1'b1);
              if (len_acc != '0) begin
                mode <= M_VALUE;
              end
              if (emit_cnt != '0) begin
                state <= S_EMIT;
              end
            end
            name_cnt  <= '0;
            name_keep <= '0;
            part      <= '0;
            len_acc   <= '0;
            len_stat  <= L_EMPTY;
          end else if (text_byte == CH_COLON) begin
            if (part < 2'd2) begin
              part <= part + 2'd1;
            end
          end else if (part == 2'd0) begin
            if (!(name_cnt == '0 && ws)) begin
              if (name_cnt < NAME_CNT_W'(3)) begin
                eor_buf[name_cnt[1:0]] <= lc;
              end
              if (!ws) begin
                name_keep <= name_cnt + 1'b1;
              end
              if (name_cnt < NAME_CNT_W'(NAME_MAX + 1)) begin
                name_cnt <= name_cnt + 1'b1;
              end
            end
          end else if (part == 2'd1) begin
            case (len_stat)
              L_EMPTY: begin
                if (digit) begin
                  len_acc  <= LW'(text_byte[3:0]);
                  len_stat <= L_DIGITS;
                end else if (!ws) begin
                  len_stat <= L_BAD;
                end
              end
              L_DIGITS: begin
                if (digit) begin
                  if (len_prod[LW+3:LW] != 4'd0) begin
                    len_stat <= L_BAD;
                  end else begin
                    len_acc <= len_prod[LW-1:0];
                  end
                end else if (ws) begin
                  len_stat <= L_CLOSED;
                end else begin
                  len_stat <= L_BAD;
                end
              end
              L_CLOSED: begin
                if (!ws) begin
                  len_stat <= L_BAD;
                end
              end
              default: ;
            endcase
          end
        end
        default: begin
          item_valid   <= 1'b1;
          item_kind    <= KIND_VALUE;
          data_byte    <= text_byte;
          value_length <= '0;
          field_end    <= (remain == LW'(1));
          run_last     <= 1'b1;
          remain       <= remain - 1'b1;
          if (remain == LW'(1)) begin
            mode <= M_SEEK;
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_value_remain: assert property (@(posedge clk) disable iff (rst)
    (mode == M_VALUE) |-> (remain != '0))
    else $error("value mode with nothing remaining");

  a_emit_mode: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (mode == M_SEEK || mode == M_VALUE))
    else $error("name emission outside a closed tag");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (emit_idx <= emit_last))
    else $error("name emission index past last character");

  // the raw count saturates one past NAME_MAX, the trimmed length may then pass the raw count by one
  a_keep_le_cnt: assert property (@(posedge clk) disable iff (rst)
    (name_keep <= name_cnt) || (name_cnt == NAME_CNT_W'(NAME_MAX + 1)))
    else $error("trimmed name longer than raw name");

  a_hdr_cnt: assert property (@(posedge clk) disable iff (rst)
    (mode != M_HEADER) |-> (hdr_cnt == '0))
    else $error("header match count left over after header scan");
`endif

endmodule
